>>> design/pbrf_pkg.sv
`default_nettype none

package pbrf_pkg;

   localparam int WORD_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int COORD_W  = 8;
   localparam int MARGIN_W = 3;
   localparam int INDEX_W  = 15;
   localparam int EXT_W    = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_PREP,
      ST_INIT,
      ST_FILL,
      ST_DRAIN,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic clip;
      logic prep;
      logic init;
      logic step;
      logic rd_issue;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> design/pbrf_ctrl.sv
`default_nettype none

module pbrf_ctrl
   import pbrf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        req_operation,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd,
   output logic             busy,
   output logic             rsp_strobe
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = req_operation ? ST_READ : ST_CLIP;
            end
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = stat.empty ? ST_RESP : ST_FILL;
         end
         ST_FILL: begin
            cmd.step = 1'b1;
            if (stat.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/pbrf_datapath.sv
`default_nettype none

module pbrf_datapath
   import pbrf_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 160
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_stat_type              stat,
   input  wire logic                req_operation,
   input  wire logic                req_buffer_select,
   input  wire logic [COORD_W-1:0]  req_rect_left,
   input  wire logic [COORD_W-1:0]  req_rect_top,
   input  wire logic [COORD_W-1:0]  req_rect_width,
   input  wire logic [COORD_W-1:0]  req_rect_height,
   input  wire logic [MARGIN_W-1:0] req_margin,
   input  wire logic [BYTE_W-1:0]   req_fill_color,
   input  wire logic [INDEX_W-1:0]  req_read_word_index,
   output logic [WORD_W-1:0]        rsp_read_data,
   output logic                     rsp_was_read
);

   localparam int WORDS = (SCREEN_WIDTH * SCREEN_HEIGHT + 1) / 2;
   localparam int DEPTH = 2 * WORDS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(SCREEN_WIDTH + 1);
   localparam int RW    = $clog2(SCREEN_HEIGHT + 1);
   localparam int PW    = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);

   logic                is_read_ff, is_read_in;
   logic                buf_ff, buf_in;
   logic [COORD_W-1:0]  left_ff, left_in;
   logic [COORD_W-1:0]  top_ff, top_in;
   logic [COORD_W-1:0]  width_ff, width_in;
   logic [COORD_W-1:0]  height_ff, height_in;
   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [BYTE_W-1:0]   color_ff, color_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [CW-1:0]       c0_ff, c0_in, c1_ff, c1_in, col_ff, col_in;
   logic [RW-1:0]       r0_ff, r0_in, r1_ff, r1_in, row_ff, row_in;
   logic [PW-1:0]       prod_ff, prod_in, skip_ff, skip_in, pix_ff, pix_in;
   logic                b_valid_ff, b_valid_in;
   logic [AW-1:0]       b_addr_ff, b_addr_in;
   logic                b_odd_ff, b_odd_in;
   logic                wr_valid_ff, wr_valid_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;
   logic [WORD_W-1:0]   wr_word_ff, wr_word_in;
   logic [WORD_W-1:0]   rd_data_ff;

   logic [WORD_W-1:0]   frame_store [DEPTH];

   logic [EXT_W-1:0]    c0_raw, c1_raw, r0_raw, r1_raw;
   logic [CW-1:0]       c0_cl, c1_cl, col_nx;
   logic [RW-1:0]       r0_cl, r1_cl, row_nx;
   logic                row_end;
   logic [AW-1:0]       base_aw, fill_addr, read_addr, rd_addr;
   logic                in_range, rd_en, fwd;
   logic [WORD_W-1:0]   src_word, merged;

   always_comb begin
      c0_raw = EXT_W'(left_ff) - EXT_W'(margin_ff);
      c1_raw = EXT_W'(left_ff) + EXT_W'(width_ff) + EXT_W'(margin_ff);
      r0_raw = EXT_W'(top_ff) - EXT_W'(margin_ff);
      r1_raw = EXT_W'(top_ff) + EXT_W'(height_ff) + EXT_W'(margin_ff);

      if (c0_raw[EXT_W-1]) begin
         c0_cl = '0;
      end else if (c0_raw > EXT_W'(SCREEN_WIDTH)) begin
         c0_cl = CW'(SCREEN_WIDTH);
      end else begin
         c0_cl = CW'(c0_raw);
      end
      c1_cl = (c1_raw > EXT_W'(SCREEN_WIDTH)) ? CW'(SCREEN_WIDTH) : CW'(c1_raw);

      if (r0_raw[EXT_W-1]) begin
         r0_cl = '0;
      end else if (r0_raw > EXT_W'(SCREEN_HEIGHT)) begin
         r0_cl = RW'(SCREEN_HEIGHT);
      end else begin
         r0_cl = RW'(r0_raw);
      end
      r1_cl = (r1_raw > EXT_W'(SCREEN_HEIGHT)) ? RW'(SCREEN_HEIGHT) : RW'(r1_raw);
   end

   assign col_nx  = col_ff + CW'(1);
   assign row_nx  = row_ff + RW'(1);
   assign row_end = (col_nx == c1_ff);

   assign stat.empty   = (c0_ff >= c1_ff) || (r0_ff >= r1_ff);
   assign stat.last    = row_end && (row_nx == r1_ff);

   assign base_aw   = buf_ff ? AW'(WORDS) : '0;
   assign fill_addr = base_aw + AW'(pix_ff >> 1);
   assign read_addr = base_aw + AW'(idx_ff);
   assign in_range  = 32'(idx_ff) < 32'(WORDS);
   assign rd_addr   = cmd.rd_issue ? (in_range ? read_addr : '0) : fill_addr;
   assign rd_en     = cmd.step || cmd.rd_issue;

   // The word written last cycle was not yet in memory when this word was read.
   assign fwd      = wr_valid_ff && (wr_addr_ff == b_addr_ff);
   assign src_word = fwd ? wr_word_ff : rd_data_ff;
   assign merged   = b_odd_ff ? {color_ff, src_word[BYTE_W-1:0]}
                              : {src_word[WORD_W-1:BYTE_W], color_ff};

   always_comb begin
      is_read_in  = is_read_ff;
      buf_in      = buf_ff;
      left_in     = left_ff;
      top_in      = top_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      margin_in   = margin_ff;
      color_in    = color_ff;
      idx_in      = idx_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      prod_in     = prod_ff;
      skip_in     = skip_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      pix_in      = pix_ff;
      b_valid_in  = cmd.step;
      b_addr_in   = fill_addr;
      b_odd_in    = col_ff[0];
      wr_valid_in = b_valid_ff;
      wr_addr_in  = b_addr_ff;
      wr_word_in  = merged;

      if (cmd.load) begin
         is_read_in = req_operation;
         buf_in     = req_buffer_select;
         left_in    = req_rect_left;
         top_in     = req_rect_top;
         width_in   = req_rect_width;
         height_in  = req_rect_height;
         margin_in  = req_margin;
         color_in   = req_fill_color;
         idx_in     = req_read_word_index;
      end
      if (cmd.clip) begin
         c0_in = c0_cl;
         c1_in = c1_cl;
         r0_in = r0_cl;
         r1_in = r1_cl;
      end
      if (cmd.prep) begin
         prod_in = PW'(PW'(r0_ff) * PW'(SCREEN_WIDTH));
         skip_in = PW'(SCREEN_WIDTH) - PW'(c1_ff) + PW'(c0_ff) + PW'(1);
      end
      if (cmd.init) begin
         pix_in = prod_ff + PW'(c0_ff);
         col_in = c0_ff;
         row_in = r0_ff;
      end
      if (cmd.step) begin
         if (row_end) begin
            col_in = c0_ff;
            row_in = row_nx;
            pix_in = pix_ff + skip_ff;
         end else begin
            col_in = col_nx;
            pix_in = pix_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         b_valid_ff  <= b_valid_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff <= is_read_in;
      buf_ff     <= buf_in;
      left_ff    <= left_in;
      top_ff     <= top_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      margin_ff  <= margin_in;
      color_ff   <= color_in;
      idx_ff     <= idx_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      prod_ff    <= prod_in;
      skip_ff    <= skip_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      pix_ff     <= pix_in;
      b_addr_ff  <= b_addr_in;
      b_odd_ff   <= b_odd_in;
      wr_addr_ff <= wr_addr_in;
      wr_word_ff <= wr_word_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_store[rd_addr];
      end
      if (b_valid_ff) begin
         frame_store[b_addr_ff] <= merged;
      end
   end

   assign rsp_read_data = (is_read_ff && in_range) ? rd_data_ff : '0;
   assign rsp_was_read  = is_read_ff;

endmodule

`default_nettype wire

>>> design/packed_byte_rect_fill.sv
// A read passes through the READ state and answers with rsp_strobe in the RESP state.
// A fill of N > 0 on-screen pixels passes through CLIP, PREP and INIT, then takes one pixel per
// cycle in FILL through the read-merge-write pipeline on the memory's read and write ports,
// drains in DRAIN and answers in RESP; a fill with no on-screen pixel skips FILL and DRAIN.
// busy is high from acceptance through the strobe cycle; the receiver cannot stall results.
// Reset returns the controller to idle; the frame buffer contents are undefined until written.
`default_nettype none

module packed_byte_rect_fill
   import pbrf_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 160
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_operation,
   input  wire logic                req_buffer_select,
   input  wire logic [COORD_W-1:0]  req_rect_left,
   input  wire logic [COORD_W-1:0]  req_rect_top,
   input  wire logic [COORD_W-1:0]  req_rect_width,
   input  wire logic [COORD_W-1:0]  req_rect_height,
   input  wire logic [MARGIN_W-1:0] req_margin,
   input  wire logic [BYTE_W-1:0]   req_fill_color,
   input  wire logic [INDEX_W-1:0]  req_read_word_index,
   output logic                     rsp_strobe,
   output logic [WORD_W-1:0]        rsp_read_data,
   output logic                     rsp_was_read
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pbrf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe)
   );

   pbrf_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_buffer_select   (req_buffer_select),
      .req_rect_left       (req_rect_left),
      .req_rect_top        (req_rect_top),
      .req_rect_width      (req_rect_width),
      .req_rect_height     (req_rect_height),
      .req_margin          (req_margin),
      .req_fill_color      (req_fill_color),
      .req_read_word_index (req_read_word_index),
      .rsp_read_data       (rsp_read_data),
      .rsp_was_read        (rsp_was_read)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy && !$past(start && !busy)))
      else $error("result strobe without a beat in flight");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_was_read) |-> (rsp_read_data == '0))
      else $error("fill completion carried nonzero data");

endmodule

`default_nettype wire
